### rtl/slis_pkg.sv
// ----------------------------------------------------------------------------
// slis_pkg
// Shared types and codes for the sorted list with insert and search.
// ----------------------------------------------------------------------------
package slis_pkg;

    localparam int SLIS_CAPACITY = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } slis_in_t;

    typedef struct packed {
        logic       status;
        logic       found;
        logic [3:0] position;
        logic [4:0] count;
    } slis_out_t;

    typedef struct packed {
        logic load_in;
        logic init_shift;
        logic idx_inc;
        logic rd_scan;
        logic rd_shift;
        logic wr_shift;
        logic jdx_dec;
        logic wr_value;
        logic cnt_inc;
        logic cnt_clr;
        logic set_hit;
        logic set_full;
        logic set_slot;
        logic load_out;
    } slis_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       idx_at_count;
        logic       less;
        logic       eq;
        logic       shift_done;
        logic       out_busy;
    } slis_stat_t;

endpackage

### rtl/slis_ctrl.sv
// ----------------------------------------------------------------------------
// slis_ctrl
// Sequencer for scan, shift and write steps of one command at a time.
// ----------------------------------------------------------------------------
module slis_ctrl
    import slis_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  slis_stat_t stat,
    output slis_cmd_t  ctl
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECODE   = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SCAN_CMP = 3'd3;
    localparam logic [2:0] ST_SHIFT    = 3'd4;
    localparam logic [2:0] ST_SHIFT_WR = 3'd5;
    localparam logic [2:0] ST_WRITE    = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.cmd)
                    CMD_INSERT: begin
                        if (stat.full) begin
                            ctl.set_full = 1'b1;
                            state_next   = ST_DONE;
                        end else begin
                            ctl.init_shift = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    CMD_SEARCH: state_next = ST_SCAN;
                    CMD_CLEAR: begin
                        ctl.cnt_clr = 1'b1;
                        state_next  = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_SCAN: begin
                if (stat.idx_at_count) begin
                    state_next = (stat.cmd == CMD_INSERT) ? ST_SHIFT : ST_DONE;
                end else begin
                    ctl.rd_scan = 1'b1;
                    state_next  = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (stat.less) begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_SCAN;
                end else if (stat.cmd == CMD_INSERT) begin
                    state_next = ST_SHIFT;
                end else begin
                    ctl.set_hit = stat.eq;
                    state_next  = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = ST_WRITE;
                end else begin
                    ctl.rd_shift = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                ctl.wr_shift = 1'b1;
                ctl.jdx_dec  = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_WRITE: begin
                ctl.wr_value = 1'b1;
                ctl.cnt_inc  = 1'b1;
                ctl.set_slot = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/slis_dp.sv
// ----------------------------------------------------------------------------
// slis_dp
// Entry memory, scan and shift pointers, entry count and result register.
// ----------------------------------------------------------------------------
module slis_dp
    import slis_pkg::*;
#(
    parameter int CAPACITY = SLIS_CAPACITY
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  slis_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output slis_out_t  m_data,
    input  slis_cmd_t  ctl,
    output slis_stat_t stat
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic signed [31:0] value_reg;
    logic [1:0]         cmd_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   jdx_reg;
    logic [CNT_W-1:0]   jdx_m1;
    logic [CNT_W-1:0]   count_reg;
    logic               hit_reg;
    logic               full_reg;
    logic               slot_reg;
    logic               m_valid_reg;
    slis_out_t          out_reg;
    logic [CNT_W+3:0]   pos_ext;
    logic [CNT_W+4:0]   cnt_ext;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;

    assign jdx_m1  = jdx_reg - CNT_W'(1);
    assign rd_en   = ctl.rd_scan | ctl.rd_shift;
    assign rd_addr = ctl.rd_shift ? jdx_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_en   = ctl.wr_shift | ctl.wr_value;
    assign wr_addr = ctl.wr_shift ? jdx_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_data = ctl.wr_shift ? rdata_reg : value_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            value_reg <= s_data.value;
            cmd_reg   <= s_data.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            jdx_reg   <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
            full_reg  <= 1'b0;
            slot_reg  <= 1'b0;
        end else begin
            if (ctl.load_in) begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                full_reg <= 1'b0;
                slot_reg <= 1'b0;
            end else if (ctl.idx_inc) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (ctl.init_shift) begin
                jdx_reg <= count_reg;
            end else if (ctl.jdx_dec) begin
                jdx_reg <= jdx_m1;
            end
            if (ctl.cnt_clr) begin
                count_reg <= '0;
            end else if (ctl.cnt_inc) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.set_hit) begin
                hit_reg <= 1'b1;
            end
            if (ctl.set_full) begin
                full_reg <= 1'b1;
            end
            if (ctl.set_slot) begin
                slot_reg <= 1'b1;
            end
        end
    end

    assign pos_ext = (hit_reg || slot_reg) ? {4'b0, idx_reg} : '0;
    assign cnt_ext = {5'b0, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            out_reg.status   <= full_reg;
            out_reg.found    <= hit_reg;
            out_reg.position <= pos_ext[3:0];
            out_reg.count    <= cnt_ext[4:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign stat.cmd          = cmd_reg;
    assign stat.full         = (count_reg == CNT_W'(CAPACITY));
    assign stat.idx_at_count = (idx_reg >= count_reg);
    assign stat.less         = (rdata_reg < value_reg);
    assign stat.eq           = (rdata_reg == value_reg);
    assign stat.shift_done   = (jdx_reg == idx_reg);
    assign stat.out_busy     = m_valid_reg && !m_ready;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.wr_shift && ctl.wr_value))
        else $error("shift and value write in the same cycle");

    a_inc_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.cnt_inc |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("insert into a full store");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rd_shift |-> (jdx_reg > idx_reg))
        else $error("shift pointer passed insert slot");

endmodule

### rtl/sorted_list_insert_search.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_search
// Bounded ascending store of signed 32-bit values with insert, search, clear.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the s_ channel (cmd, value); each command gives
// exactly one result beat on the m_ channel (status, found, position, count).
// One command is worked on at a time, sequenced over a single-port entry
// memory with a registered read. A search scans the entries from the head,
// reading and comparing each one in turn until one is not below the value.
// An insert scans the same way, then shifts each entry at or after the insert
// slot up one place, one read and one write per entry from the tail down, and
// writes the value. An insert into a full store, a clear and an unused code go
// straight to the result.
// s_ready rises in the cycle after the result loads into the output register,
// even while that result still waits for m_ready, so the next command beat
// can be accepted before that result is taken. A stalled receiver holds the
// block in its final step once a second result is ready.
// Reset (aresetn low, synchronous) empties the store and drops any pending
// result; entry memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_insert_search
    import slis_pkg::*;
#(
    parameter int CAPACITY = SLIS_CAPACITY
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  slis_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output slis_out_t m_data
);

    slis_cmd_t  ctl;
    slis_stat_t stat;

    slis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    slis_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .ctl     (ctl),
        .stat    (stat)
    );

endmodule

### verif/tb_sorted_list_insert_search.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_search
// Self-checking bench for the bounded sorted store with insert, search, clear.
// ----------------------------------------------------------------------------
// A short directed table covers the extremes, every command and the special
// cases: head insert, equal values, search miss, full store and unused code.
// A random part follows in three phases with different gap and stall rates on
// both channels. Every accepted command runs through a local copy of the
// sorted store. Each result beat is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_search
    import slis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_PER_PHASE = 475;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int DIR_ROWS = 25;

    typedef struct packed {
        slis_in_t  beat;
        logic      typed;
        slis_out_t want;
    } dir_row_t;

    localparam slis_out_t NO_WANT = '0;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    slis_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    slis_out_t m_data;

    logic      cur_typed = 1'b0;
    slis_out_t cur_want = '0;

    logic signed [31:0] list_vals [SLIS_CAPACITY];
    int list_len = 0;
    slis_out_t pending_results [$];

    int n_in_beats = 0;
    int n_out_beats = 0;
    int n_errors = 0;
    int n_inserts = 0;
    int n_refused = 0;
    int n_searches = 0;
    int n_hits = 0;
    int n_clears = 0;
    int n_unused = 0;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{'{CMD_SEARCH, 32'sd0},     1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd0}},
        '{'{CMD_CLEAR,  32'sd0},     1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd0}},
        '{'{CMD_INSERT, VAL_MAX},    1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd1}},
        '{'{CMD_INSERT, VAL_MIN},    1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd2}},
        '{'{CMD_UNUSED, 32'sd5},     1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd2}},
        '{'{CMD_INSERT, 32'sd0},     1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd0},     1'b0, NO_WANT},
        '{'{CMD_SEARCH, 32'sd0},     1'b0, NO_WANT},
        '{'{CMD_SEARCH, -32'sd1},    1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd4}},
        '{'{CMD_SEARCH, VAL_MIN},    1'b1, '{STAT_OK, 1'b1, 4'd0, 5'd4}},
        '{'{CMD_SEARCH, VAL_MAX},    1'b0, NO_WANT},
        '{'{CMD_INSERT, -32'sd7},    1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd3},     1'b0, NO_WANT},
        '{'{CMD_INSERT, VAL_MAX},    1'b0, NO_WANT},
        '{'{CMD_INSERT, VAL_MIN},    1'b0, NO_WANT},
        '{'{CMD_INSERT, -32'sd1},    1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd1},     1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd100},   1'b0, NO_WANT},
        '{'{CMD_INSERT, -32'sd100},  1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd0},     1'b0, NO_WANT},
        '{'{CMD_INSERT, VAL_MAX - 1}, 1'b0, NO_WANT},
        '{'{CMD_INSERT, VAL_MIN + 1}, 1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd42},    1'b0, NO_WANT},
        '{'{CMD_INSERT, 32'sd5},     1'b1, '{STAT_FULL, 1'b0, 4'd0, 5'd16}},
        '{'{CMD_CLEAR,  32'sd9},     1'b1, '{STAT_OK, 1'b0, 4'd0, 5'd0}}
    };

    sorted_list_insert_search i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic slis_out_t apply_list_op(slis_in_t op);
        slis_out_t res;
        int slot;
        res = '0;
        slot = 0;
        while (slot < list_len && list_vals[slot] < op.value)
            slot++;
        case (op.cmd)
            CMD_INSERT: begin
                n_inserts++;
                if (list_len >= SLIS_CAPACITY) begin
                    res.status = STAT_FULL;
                    n_refused++;
                end else begin
                    for (int j = list_len; j > slot; j--)
                        list_vals[j] = list_vals[j - 1];
                    list_vals[slot] = op.value;
                    list_len++;
                    res.position = slot[3:0];
                end
            end
            CMD_SEARCH: begin
                n_searches++;
                if (slot < list_len && list_vals[slot] == op.value) begin
                    res.found = 1'b1;
                    res.position = slot[3:0];
                    n_hits++;
                end
            end
            CMD_CLEAR: begin
                n_clears++;
                list_len = 0;
            end
            default: n_unused++;
        endcase
        res.count = 5'(list_len);
        return res;
    endfunction

    function automatic string fmt_out(slis_out_t r);
        return $sformatf("status=%0d found=%0d position=%0d count=%0d",
                         r.status, r.found, r.position, r.count);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return int'($urandom_range(0, 20)) - 10;
        if (r < 72) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX;
                3: return VAL_MAX - 1;
                4: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return CMD_INSERT;
        if (r < 94)
            return CMD_SEARCH;
        if (r < 97)
            return CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    task automatic offer_beat(input slis_in_t beat, input logic typed, input slis_out_t want);
        int seen;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        seen = n_in_beats;
        s_valid <= 1'b1;
        s_data <= beat;
        cur_typed <= typed;
        cur_want <= want;
        do @(negedge aclk); while (n_in_beats == seen);
    endtask

    task automatic run_random(input int n_items, input int hold_at);
        slis_in_t beat;
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at)
                hold_left = HOLD_CYCLES;
            beat.cmd = pick_cmd();
            beat.value = pick_value();
            offer_beat(beat, 1'b0, NO_WANT);
        end
    endtask

    always @(posedge aclk) begin
        slis_out_t want_res;
        slis_out_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want_res = apply_list_op(s_data);
                if (cur_typed)
                    want_res = cur_want;
                pending_results.push_back(want_res);
                n_in_beats++;
            end
            if (m_valid && m_ready) begin
                got = m_data;
                n_out_beats++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result beat: %s", $time, fmt_out(got));
                end else begin
                    want_res = pending_results.pop_front();
                    if (got.status !== want_res.status || got.found !== want_res.found ||
                        got.position !== want_res.position || got.count !== want_res.count) begin
                        n_errors++;
                        $display("%0t: result %0d mismatch: expected %s, got %s",
                                 $time, n_out_beats, fmt_out(want_res), fmt_out(got));
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_gap_pct = 13;
        recv_stall_pct = 79;
        for (int i = 0; i < DIR_ROWS; i++)
            offer_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].want);
        run_random(RANDOM_PER_PHASE, 100);

        send_gap_pct = 79;
        recv_stall_pct = 13;
        run_random(RANDOM_PER_PHASE, -1);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_PHASE, 200);

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Ran %0d commands: %0d inserts (%0d refused when full), %0d searches (%0d hits),",
                 n_in_beats, n_inserts, n_refused, n_searches, n_hits);
        $display("%0d clears and %0d unused codes; %0d result beats checked, %0d errors.",
                 n_clears, n_unused, n_out_beats, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/slis_pkg.sv
rtl/slis_ctrl.sv
rtl/slis_dp.sv
rtl/sorted_list_insert_search.sv
verif/tb_sorted_list_insert_search.sv
